// ----- hw/rtl/next_fit_chunk_allocator_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Next-fit chunk allocator: assertion macros
// Shared concurrent assertion forms; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef NEXT_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH
`define NEXT_FIT_CHUNK_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset
`define NFCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define NFCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NFCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define NFCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/nfca_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nfca_pkg
// Constants, codes and shared types of the next-fit chunk allocator.
// ---------------------------------------------------------------------------
package nfca_pkg;

    // Pool limits
    localparam int MAX_CHUNKS      = 256;
    localparam int MAX_CHUNK_BYTES = 65536;

    // Field widths
    localparam int IDX_W    = $clog2(MAX_CHUNKS);
    localparam int COUNT_W  = 9;
    localparam int BYTES_W  = 17;
    localparam int OFFSET_W = 24;
    localparam int STATUS_W = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CHUNK_COUNT = 1'b0;
    localparam logic REG_CHUNK_BYTES = 1'b1;
    localparam logic [COUNT_W-1:0] CHUNK_COUNT_RESET = COUNT_W'(256);
    localparam logic [BYTES_W-1:0] CHUNK_BYTES_RESET = BYTES_W'(64);

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    // Divider: one quotient bit per cycle
    localparam int DIV_STEPS = OFFSET_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                start;
        logic [OFFSET_W-1:0] dividend;
        logic [BYTES_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [OFFSET_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hw/rtl/nfca_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nfca_in_if
// Request channel: allocate or free one chunk.
// ---------------------------------------------------------------------------
interface nfca_in_if;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [nfca_pkg::OFFSET_W-1:0] chunk_offset;

    modport source (output valid, output kind, output chunk_offset, input ready);
    modport sink   (input valid, input kind, input chunk_offset, output ready);

endinterface

// ----- hw/rtl/nfca_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nfca_out_if
// Response channel: status, chunk index and byte offset of one item.
// ---------------------------------------------------------------------------
interface nfca_out_if;

    logic                          valid;
    logic                          ready;
    logic [nfca_pkg::STATUS_W-1:0] status;
    logic [nfca_pkg::IDX_W-1:0]    chunk_index;
    logic [nfca_pkg::OFFSET_W-1:0] result_offset;

    modport source (output valid, output status, output chunk_index, output result_offset,
                    input ready);
    modport sink   (input valid, input status, input chunk_index, input result_offset,
                    output ready);

endinterface

// ----- hw/rtl/nfca_divider.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nfca_divider
// Restoring divider, one quotient bit per cycle, turns a byte offset into a
// chunk index. done pulses for one cycle; the quotient holds until restarted.
// ---------------------------------------------------------------------------
module nfca_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  nfca_pkg::div_req_t div_req,
    output nfca_pkg::div_rsp_t div_rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [nfca_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [nfca_pkg::OFFSET_W-1:0]       quo_reg;
    logic [nfca_pkg::BYTES_W-1:0]        rem_reg;
    logic [nfca_pkg::BYTES_W-1:0]        dvs_reg;

    logic [nfca_pkg::BYTES_W:0]          shifted;
    logic                                take;
    logic [nfca_pkg::BYTES_W:0]          diff;
    logic [nfca_pkg::BYTES_W-1:0]        rem_next;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[nfca_pkg::OFFSET_W-1]};
        take     = (shifted >= {1'b0, dvs_reg});
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = take ? diff[nfca_pkg::BYTES_W-1:0] : shifted[nfca_pkg::BYTES_W-1:0];
    end

    // Control: start, count steps, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (div_req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == nfca_pkg::DIV_CNT_W'(nfca_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift quotient bits in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            quo_reg <= div_req.dividend;
            rem_reg <= '0;
            dvs_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[nfca_pkg::OFFSET_W-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

// ----- hw/rtl/next_fit_chunk_allocator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// next_fit_chunk_allocator_unit
// Fixed-size chunk pool allocator with a next-fit search over a mark memory.
// ---------------------------------------------------------------------------
// After reset the block sweeps the 256-entry mark memory clear, one entry a
// cycle, and takes no request until the sweep is done (register writes are
// taken throughout). One request is worked at a time. An allocate reads one
// mark a cycle from the search pointer onward through the single read port of
// the mark memory. A free runs the offset through a one-bit-a-cycle divider.
// A finished response waits in an output register, so the next request is
// taken while it is still pending. Registers: chunk_count at byte address 0,
// chunk_bytes at byte address 4.
// ---------------------------------------------------------------------------
`include "next_fit_chunk_allocator_unit_defines.svh"

module next_fit_chunk_allocator_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    nfca_in_if.sink                      req,
    nfca_out_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nfca_pkg::PADDR_W-1:0] paddr,
    input  logic [nfca_pkg::PDATA_W-1:0] pwdata,
    output logic [nfca_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int IDX_W    = nfca_pkg::IDX_W;
    localparam int COUNT_W  = nfca_pkg::COUNT_W;
    localparam int BYTES_W  = nfca_pkg::BYTES_W;
    localparam int OFFSET_W = nfca_pkg::OFFSET_W;
    localparam int STATUS_W = nfca_pkg::STATUS_W;

    // Controller states
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    // Configuration
    logic [COUNT_W-1:0]  chunk_count_reg;
    logic [BYTES_W-1:0]  chunk_bytes_reg;
    logic [COUNT_W-1:0]  eff_count;
    logic [BYTES_W-1:0]  eff_bytes;
    logic                cfg_write;

    // Mark memory
    logic                marks_mem [nfca_pkg::MAX_CHUNKS];
    logic                mark_rdata_reg;
    logic [IDX_W-1:0]    mark_raddr;
    logic                mark_we;
    logic [IDX_W-1:0]    mark_waddr;
    logic                mark_wdata;

    // Control
    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]    ptr_reg;
    logic [IDX_W-1:0]    ptr_next;
    logic [IDX_W-1:0]    issue_addr_reg;
    logic [IDX_W-1:0]    issue_addr_next;
    logic [COUNT_W-1:0]  issue_left_reg;
    logic [COUNT_W-1:0]  issue_left_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [IDX_W-1:0]    pend_addr_reg;
    logic [IDX_W-1:0]    pend_addr_next;

    // Pending result
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic [IDX_W-1:0]    res_idx_reg;
    logic [IDX_W-1:0]    res_idx_next;
    logic                res_alloc_reg;
    logic                res_alloc_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_load;
    logic [IDX_W+BYTES_W-1:0] offset_prod;

    // Handshakes and scan decisions
    logic                req_fire;
    logic                scan_issue;
    logic                scan_found;
    logic [IDX_W-1:0]    start_addr;

    // Divider link
    nfca_pkg::div_req_t  div_req;
    nfca_pkg::div_rsp_t  div_rsp;

    // Step a chunk index forward, wrapping at the effective count
    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] a,
                                                   input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] inc;
        inc = {1'b0, a} + 1'b1;
        return (inc >= cnt) ? '0 : inc[IDX_W-1:0];
    endfunction

    // Clamp register values into their working ranges
    always_comb
    begin
        if (chunk_count_reg > COUNT_W'(nfca_pkg::MAX_CHUNKS))
            eff_count = COUNT_W'(nfca_pkg::MAX_CHUNKS);
        else
            eff_count = chunk_count_reg;
        if (chunk_bytes_reg == '0)
            eff_bytes = BYTES_W'(1);
        else if (chunk_bytes_reg > BYTES_W'(nfca_pkg::MAX_CHUNK_BYTES))
            eff_bytes = BYTES_W'(nfca_pkg::MAX_CHUNK_BYTES);
        else
            eff_bytes = chunk_bytes_reg;
    end

    // Register port: write on the access phase, read back raw values
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == nfca_pkg::REG_CHUNK_BYTES)
                       ? {{(nfca_pkg::PDATA_W-BYTES_W){1'b0}}, chunk_bytes_reg}
                       : {{(nfca_pkg::PDATA_W-COUNT_W){1'b0}}, chunk_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_count_reg <= nfca_pkg::CHUNK_COUNT_RESET;
            chunk_bytes_reg <= nfca_pkg::CHUNK_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == nfca_pkg::REG_CHUNK_COUNT)
                chunk_count_reg <= pwdata[COUNT_W-1:0];
            else
                chunk_bytes_reg <= pwdata[BYTES_W-1:0];
        end
    end

    // Mark memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mark_we)
            marks_mem[mark_waddr] <= mark_wdata;
        mark_rdata_reg <= marks_mem[mark_raddr];
    end

    assign mark_raddr = issue_addr_reg;

    // Divider for free requests
    assign div_req.start    = req_fire && (req.kind == nfca_pkg::KIND_FREE);
    assign div_req.dividend = req.chunk_offset;
    assign div_req.divisor  = eff_bytes;

    nfca_divider u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign start_addr = ({1'b0, ptr_reg} >= eff_count) ? '0 : ptr_reg;
    assign scan_issue = (issue_left_reg != '0);
    assign scan_found = pend_valid_reg && !mark_rdata_reg;

    // Sequencer: clear sweep, mark scan, divide, respond
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        issue_addr_next = issue_addr_reg;
        issue_left_next = issue_left_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_alloc_next  = res_alloc_reg;
        mark_we         = 1'b0;
        mark_waddr      = clr_addr_reg;
        mark_wdata      = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                mark_we = 1'b1;
                if (clr_addr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.kind == nfca_pkg::KIND_ALLOC)
                    begin
                        issue_addr_next = start_addr;
                        issue_left_next = eff_count;
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    // Claim the free chunk and move the pointer past it
                    mark_we         = 1'b1;
                    mark_waddr      = pend_addr_reg;
                    mark_wdata      = 1'b1;
                    ptr_next        = wrap_next(pend_addr_reg, eff_count);
                    res_status_next = nfca_pkg::STAT_OK;
                    res_idx_next    = pend_addr_reg;
                    res_alloc_next  = 1'b1;
                    state_next      = S_RESULT;
                end
                else if (!scan_issue)
                begin
                    res_status_next = nfca_pkg::STAT_FULL;
                    res_idx_next    = '0;
                    res_alloc_next  = 1'b0;
                    state_next      = S_RESULT;
                end
                else
                begin
                    issue_addr_next = wrap_next(issue_addr_reg, eff_count);
                    issue_left_next = issue_left_reg - 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = issue_addr_reg;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_alloc_next = 1'b0;
                    if (div_rsp.quotient >= {{(OFFSET_W-COUNT_W){1'b0}}, eff_count})
                    begin
                        res_status_next = nfca_pkg::STAT_RANGE;
                        res_idx_next    = '0;
                    end
                    else
                    begin
                        // Release the chunk
                        mark_we         = 1'b1;
                        mark_waddr      = div_rsp.quotient[IDX_W-1:0];
                        mark_wdata      = 1'b0;
                        res_status_next = nfca_pkg::STAT_OK;
                        res_idx_next    = div_rsp.quotient[IDX_W-1:0];
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            ptr_reg        <= '0;
            issue_left_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            issue_left_reg <= issue_left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (state_reg == S_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        issue_addr_reg <= issue_addr_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_alloc_reg  <= res_alloc_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_offset_reg <= res_alloc_reg ? offset_prod[OFFSET_W-1:0] : '0;
        end
    end

    // Byte offset of an allocated chunk
    assign offset_prod = {{BYTES_W{1'b0}}, res_idx_reg} * {{IDX_W{1'b0}}, eff_bytes};

    // Hold the response until taken
    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.chunk_index   = out_idx_reg;
    assign rsp.result_offset = out_offset_reg;

    `NFCA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n,
        req_fire, !req.ready, "request taken while busy")
    `NFCA_ASSERT_IMPLY(a_scan_bounded, clk, rst_n,
        state_reg == S_SCAN, issue_left_reg <= eff_count, "scan longer than pool")
    `NFCA_ASSERT_IMPLY(a_ptr_in_pool, clk, rst_n,
        (state_reg == S_RESULT) && res_alloc_reg,
        ({1'b0, ptr_reg} < eff_count) || (ptr_reg == '0), "pointer past pool")
    `NFCA_ASSERT_IMPLY(a_ok_in_pool, clk, rst_n,
        (state_reg == S_RESULT) && (res_status_reg == nfca_pkg::STAT_OK),
        {1'b0, res_idx_reg} < eff_count, "index past pool")
    `NFCA_ASSERT_IMPLY(a_alloc_ok, clk, rst_n,
        res_alloc_reg && (state_reg == S_RESULT),
        res_status_reg == nfca_pkg::STAT_OK, "offset on failed item")

endmodule

// ----- tb/sv/next_fit_chunk_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// next_fit_chunk_allocator_unit_tb
// Self-checking bench for the next-fit chunk allocator. A short directed plan
// walks the corner cases of allocate, free and the pool registers. Random
// phases then run under several register settings and handshake idle
// patterns. Replies are checked against typed plan rows or the bench model.
// ---------------------------------------------------------------------------
module next_fit_chunk_allocator_unit_tb;

    import nfca_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    chunk_index;
        logic [OFFSET_W-1:0] result_offset;
    } chunk_reply_t;

    typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_SET_COUNT, ROW_SET_BYTES} row_op_e;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct {
        row_op_e             op;
        logic [OFFSET_W-1:0] arg;
        logic                typed;
        chunk_reply_t        reply;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    nfca_in_if  req_ch ();
    nfca_out_if rsp_ch ();

    // Pool model state
    bit                  chunk_used [0:MAX_CHUNKS-1];
    int unsigned         scan_ptr;
    logic [COUNT_W-1:0]  pool_count;
    logic [BYTES_W-1:0]  pool_bytes;

    chunk_reply_t        reply_q [$];
    plan_row_t           plan_q [$];
    int                  send_idle_pct = 0;
    int                  rsp_stall_pct = 0;
    int                  fail_count    = 0;

    next_fit_chunk_allocator_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Chunk count in force: saturate at the pool size
    function automatic int unsigned pool_limit();
        return (pool_count > MAX_CHUNKS) ? MAX_CHUNKS : pool_count;
    endfunction

    // Chunk size in force: zero acts as one, saturate at the largest chunk
    function automatic int unsigned pool_size();
        if (pool_bytes == '0)
            return 1;
        return (pool_bytes > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : pool_bytes;
    endfunction

    // Advance the pool model by one request and return its reply
    function automatic chunk_reply_t pool_predict(input logic req_kind,
                                                  input logic [OFFSET_W-1:0] off);
        chunk_reply_t r;
        int unsigned  lim;
        int unsigned  size;
        int unsigned  p;
        int unsigned  n;
        int unsigned  quo;
        bit           found;
        lim   = pool_limit();
        size  = pool_size();
        r     = '0;
        found = 1'b0;
        if (req_kind == KIND_ALLOC) begin
            r.status = STAT_FULL;
            p = (scan_ptr >= lim) ? 0 : scan_ptr;
            for (n = 0; n < lim && !found; n++) begin
                if (!chunk_used[p]) begin
                    chunk_used[p]   = 1'b1;
                    found           = 1'b1;
                    r.status        = STAT_OK;
                    r.chunk_index   = IDX_W'(p);
                    r.result_offset = OFFSET_W'(p * size);
                    scan_ptr        = (p + 1 >= lim) ? 0 : p + 1;
                end else begin
                    p = (p + 1 >= lim) ? 0 : p + 1;
                end
            end
        end else begin
            quo = off / size;
            if (quo >= lim) begin
                r.status = STAT_RANGE;
            end else begin
                chunk_used[quo] = 1'b0;
                r.status        = STAT_OK;
                r.chunk_index   = IDX_W'(quo);
            end
        end
        return r;
    endfunction

    function automatic void add_row(input row_op_e op, input logic [OFFSET_W-1:0] arg,
                                    input logic typed, input logic [STATUS_W-1:0] st,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [OFFSET_W-1:0] off);
        plan_row_t row;
        row.op                  = op;
        row.arg                 = arg;
        row.typed               = typed;
        row.reply.status        = st;
        row.reply.chunk_index   = idx;
        row.reply.result_offset = off;
        plan_q.push_back(row);
    endfunction

    // Offer one item, hold it until taken, then queue its expected reply
    task automatic send_item(input logic req_kind, input logic [OFFSET_W-1:0] off,
                             input logic typed, input chunk_reply_t typed_reply);
        chunk_reply_t guess;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= req_kind;
        req_ch.chunk_offset <= off;
        do @(posedge clk); while (!req_ch.ready);
        guess = pool_predict(req_kind, off);
        reply_q.push_back(typed ? typed_reply : guess);
    endtask

    // Drop valid and wait until every pending reply is back
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup then access cycle; the model register follows the write
    task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_CHUNK_COUNT)
            pool_count = value[COUNT_W-1:0];
        else
            pool_bytes = value[BYTES_W-1:0];
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 81; rsp_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  rsp_stall_pct = 81; end
            default:   begin send_idle_pct = 14; rsp_stall_pct = 14; end
        endcase
    endtask

    // One random phase under a fixed register setting
    task automatic run_phase(input int unsigned count, input int unsigned bytes,
                             input idle_mode_e mode, input int unsigned n_items,
                             input int unsigned alloc_pct);
        int unsigned         lim;
        int unsigned         size;
        int unsigned         idx;
        int unsigned         pick;
        int unsigned         k;
        logic [OFFSET_W-1:0] off;
        logic                req_kind;
        settle();
        apb_write(REG_CHUNK_COUNT, PDATA_W'(count));
        apb_write(REG_CHUNK_BYTES, PDATA_W'(bytes));
        set_idle(mode);
        lim  = pool_limit();
        size = pool_size();
        for (k = 0; k < n_items; k++) begin
            // Hold off mid-phase until the pool has answered everything
            if (k == n_items / 2)
                settle();
            pick = $urandom_range(99);
            off  = OFFSET_W'($urandom);
            if ($urandom_range(99) < alloc_pct) begin
                req_kind = KIND_ALLOC;
            end else begin
                req_kind = KIND_FREE;
                if (lim != 0 && pick < 75) begin
                    idx = $urandom_range(lim - 1);
                    off = OFFSET_W'(idx * size + $urandom_range(size - 1));
                end else if (pick < 90 && lim * size <= 32'hFF_FFFF) begin
                    off = OFFSET_W'($urandom_range(32'hFF_FFFF, lim * size));
                end
            end
            send_item(req_kind, off, 1'b0, '0);
        end
    endtask

    // Reply side: check each taken item, then pick ready for the next edge
    always @(posedge clk) begin : reply_check
        chunk_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (reply_q.size() == 0) begin
                $error("reply with none pending: status %0d index %0d offset %0h",
                       rsp_ch.status, rsp_ch.chunk_index, rsp_ch.result_offset);
                fail_count++;
            end else begin
                want = reply_q.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.chunk_index !== want.chunk_index) begin
                    $error("chunk_index: expected %0d, got %0d",
                           want.chunk_index, rsp_ch.chunk_index);
                    fail_count++;
                end
                if (rsp_ch.result_offset !== want.result_offset) begin
                    $error("result_offset: expected %0h, got %0h",
                           want.result_offset, rsp_ch.result_offset);
                    fail_count++;
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Hard stop if the run hangs
    initial begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : main_seq
        int unsigned r;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.chunk_offset = '0;
        rsp_ch.ready        = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        foreach (chunk_used[i])
            chunk_used[i] = 1'b0;
        scan_ptr   = 0;
        pool_count = CHUNK_COUNT_RESET;
        pool_bytes = CHUNK_BYTES_RESET;

        // Directed plan, starting from the reset registers (256 chunks of 64 bytes)
        add_row(ROW_ALLOC, 24'd0,       1'b1, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b1, STAT_OK,    8'd1,   24'd64);
        add_row(ROW_FREE,  24'd64,      1'b1, STAT_OK,    8'd1,   24'd0);
        // Offset inside a chunk frees the chunk holding it
        add_row(ROW_FREE,  24'd63,      1'b1, STAT_OK,    8'd0,   24'd0);
        // Chunk already free still succeeds
        add_row(ROW_FREE,  24'd0,       1'b1, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_FREE,  24'hFFFFFF,  1'b1, STAT_RANGE, 8'd0,   24'd0);
        add_row(ROW_FREE,  24'd16384,   1'b1, STAT_RANGE, 8'd0,   24'd0);
        add_row(ROW_FREE,  24'd16383,   1'b1, STAT_OK,    8'd255, 24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b0, STAT_OK,    8'd0,   24'd0);
        // Shrink below the pointer, zero chunk size acts as one byte
        add_row(ROW_SET_COUNT, 24'd2,   1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_SET_BYTES, 24'd0,   1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'hFFFFFF,  1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b1, STAT_FULL,  8'd0,   24'd0);
        add_row(ROW_FREE,  24'd1,       1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_FREE,  24'd2,       1'b1, STAT_RANGE, 8'd0,   24'd0);
        // Empty pool
        add_row(ROW_SET_COUNT, 24'd0,   1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b1, STAT_FULL,  8'd0,   24'd0);
        add_row(ROW_FREE,  24'd0,       1'b1, STAT_RANGE, 8'd0,   24'd0);
        // Both registers above their limits; marks beyond the old count survive
        add_row(ROW_SET_COUNT, 24'd511,    1'b0, STAT_OK, 8'd0,   24'd0);
        add_row(ROW_SET_BYTES, 24'd131071, 1'b0, STAT_OK, 8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_FREE,  24'hFF0000,  1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_FREE,  24'hFFFFFF,  1'b0, STAT_OK,    8'd0,   24'd0);
        add_row(ROW_ALLOC, 24'd0,       1'b0, STAT_OK,    8'd0,   24'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan_q[i]) begin
            case (plan_q[i].op)
                ROW_ALLOC: send_item(KIND_ALLOC, plan_q[i].arg, plan_q[i].typed,
                                     plan_q[i].reply);
                ROW_FREE:  send_item(KIND_FREE, plan_q[i].arg, plan_q[i].typed,
                                     plan_q[i].reply);
                ROW_SET_COUNT:
                begin
                    settle();
                    apb_write(REG_CHUNK_COUNT, PDATA_W'(plan_q[i].arg));
                end
                default:
                begin
                    settle();
                    apb_write(REG_CHUNK_BYTES, PDATA_W'(plan_q[i].arg));
                end
            endcase
        end

        // Random phases over several pool settings and idle patterns
        run_phase(256, 64,     IDLE_NONE, 200, 60);
        run_phase(8,   1,      IDLE_SEND, 200, 55);
        run_phase(1,   65536,  IDLE_RECV, 150, 50);
        run_phase(16,  0,      IDLE_BOTH, 200, 55);
        run_phase(511, 131071, IDLE_NONE, 300, 85);
        run_phase(3,   5,      IDLE_RECV, 150, 50);
        run_phase(0,   7,      IDLE_SEND, 40,  50);
        run_phase(100, 1000,   IDLE_BOTH, 200, 60);
        for (r = 0; r < 3; r++)
            run_phase($urandom_range(300, 1), $urandom_range(131071, 0),
                      idle_mode_e'($urandom_range(3)), 100, $urandom_range(80, 40));

        // Drain, then leave room for any stray reply
        settle();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/nfca_pkg.sv
hw/rtl/nfca_in_if.sv
hw/rtl/nfca_out_if.sv
hw/rtl/nfca_divider.sv
hw/rtl/next_fit_chunk_allocator_unit.sv
tb/sv/next_fit_chunk_allocator_unit_tb.sv
